>>> hw/rtl/hkf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hkf_pkg
// shared types and constants of the hot key frequency counter
// ----------------------------------------------------------------------------
package hkf_pkg;

   localparam logic [63:0] HASH_MULT    = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [16:0] BOTTOM_START = 17'd99999;
   localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

   localparam logic MODE_INCREMENT = 1'b0;
   localparam logic MODE_LOOKUP    = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [63:0] key;
   } req_type;

   typedef struct packed {
      logic [31:0] key_count;
      logic [31:0] top_count;
      logic [63:0] top_key;
      logic [16:0] bottom_count;
      logic [63:0] bottom_key;
      logic        table_full;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic [31:0] count;
   } slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/hkf_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hkf_hash
// five stage home slot unit: 64-bit multiplicative hash, then the upper word
// reduced modulo the table size by reciprocal multiply and one correction
// ----------------------------------------------------------------------------
module hkf_hash
   import hkf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [63:0]                      key,
   output      logic                             done,
   output      logic [$clog2(TABLE_ENTRIES)-1:0] home
);

   localparam int          IDX_W      = $clog2(TABLE_ENTRIES);
   localparam logic [63:0] RECIP_WIDE = (64'd1 << 32) / 64'(TABLE_ENTRIES);
   localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
   localparam logic [31:0] ENTRIES_32 = 32'(TABLE_ENTRIES);

   logic [4:0]       stage_ff;
   logic [63:0]      ll_ff;
   logic [31:0]      lh_ff;
   logic [31:0]      hl_ff;
   logic [31:0]      h_ff;
   logic [31:0]      h2_ff;
   logic [31:0]      h3_ff;
   logic [63:0]      qp_ff;
   logic [31:0]      qn_ff;
   logic [IDX_W-1:0] home_ff;
   logic [31:0]      diff;
   logic [31:0]      rem_fix;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= {stage_ff[3:0], start};
      end
   end

   // partial products of the low 64 bits of key * HASH_MULT, then modulo
   always_ff @(posedge clock) begin
      ll_ff <= {32'd0, key[31:0]} * {32'd0, HASH_MULT[31:0]};
      lh_ff <= key[31:0] * HASH_MULT[63:32];
      hl_ff <= key[63:32] * HASH_MULT[31:0];
      h_ff  <= ll_ff[63:32] + lh_ff + hl_ff;
      h2_ff <= h_ff;
      qp_ff <= {32'd0, h_ff} * {32'd0, RECIP};
      h3_ff <= h2_ff;
      qn_ff <= qp_ff[63:32] * ENTRIES_32;
      if (stage_ff[3]) begin
         home_ff <= rem_fix[IDX_W-1:0];
      end
   end

   always_comb begin
      diff    = h3_ff - qn_ff;
      rem_fix = (diff >= ENTRIES_32) ? (diff - ENTRIES_32) : diff;
   end

   assign done = stage_ff[4];
   assign home = home_ff;

endmodule

`default_nettype wire

>>> hw/rtl/hkf_slot_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hkf_slot_ram
// slot memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module hkf_slot_ram
   import hkf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   output      slot_type                         rd_data,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   input  wire slot_type                         wr_data
);

   slot_type slot_mem_ff [TABLE_ENTRIES];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/hot_key_frequency_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hot_key_frequency_counter
// occurrence counter for 64-bit keys in an open-addressed hashed table
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one item {mode, key}; mode increment bumps the key's
//   count (inserting it at 1), mode lookup only reads it. rsp carries one item
//   per request: the key's count, the running top and bottom counts with
//   their keys, and the table full flag.
//   after reset the block sweeps the slot memory, one slot a cycle, with
//   req_stall high; the table is then empty. one item is worked on at a
//   time: an accept step, the hash, for each probed slot a memory read,
//   then a compare and write back, and a load of the output register;
//   probes run from 1 to PROBE_LIMIT.
//   the result sits in an output register; a stall on rsp holds it there
//   while the next item is accepted and processed, and that item waits in
//   the output stage until the register is free.
// ----------------------------------------------------------------------------
module hot_key_frequency_counter
   import hkf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024,
   parameter int PROBE_LIMIT   = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   localparam int               IDX_W      = $clog2(TABLE_ENTRIES);
   localparam int               PCNT_W     = $clog2(PROBE_LIMIT + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [PCNT_W-1:0] LAST_PROBE = PCNT_W'(PROBE_LIMIT - 1);

   state_type         state_ff;
   state_type         state_in;
   logic              mode_ff;
   logic [63:0]       key_ff;
   logic [IDX_W-1:0]  addr_ff;
   logic [PCNT_W-1:0] probe_cnt_ff;
   logic [IDX_W-1:0]  clr_idx_ff;
   logic [31:0]       count_ff;
   logic              full_ff;
   logic [31:0]       best_count_ff;
   logic [63:0]       best_key_ff;
   logic [16:0]       least_count_ff;
   logic [63:0]       least_key_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              req_accept;
   logic              hash_done;
   logic [IDX_W-1:0]  hash_home;
   slot_type          rd_data;
   logic              mem_rd;
   logic              mem_wr;
   logic [IDX_W-1:0]  mem_wr_addr;
   slot_type          mem_wr_data;
   logic              rsp_load;

   logic              hit;
   logic              empty;
   logic              last_probe;
   logic              probe_end;
   logic              do_write;
   logic [31:0]       inc_count;
   logic [31:0]       new_count;
   logic [31:0]       res_count;
   logic              res_full;
   logic [IDX_W-1:0]  next_addr;

   assign req_accept = req_valid && !req_stall;

   hkf_hash #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_hash (
      .clock(clock),
      .reset(reset),
      .start(req_accept),
      .key  (req_data.key),
      .done (hash_done),
      .home (hash_home)
   );

   hkf_slot_ram #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_slot_ram (
      .clock  (clock),
      .rd_en  (mem_rd),
      .rd_addr(addr_ff),
      .rd_data(rd_data),
      .wr_en  (mem_wr),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data)
   );

   // probe evaluation on the slot just read
   always_comb begin
      hit        = rd_data.valid && (rd_data.key == key_ff);
      empty      = !rd_data.valid;
      last_probe = (probe_cnt_ff == LAST_PROBE);
      probe_end  = hit || empty || last_probe;
      inc_count  = (rd_data.count == COUNT_MAX) ? rd_data.count : rd_data.count + 32'd1;
      new_count  = hit ? inc_count : 32'd1;
      next_addr  = (addr_ff == LAST_SLOT) ? '0 : addr_ff + 1'b1;
      if (mode_ff == MODE_LOOKUP) begin
         res_count = hit ? rd_data.count : 32'd0;
         res_full  = 1'b0;
      end else begin
         res_count = (hit || empty) ? new_count : 32'd0;
         res_full  = !(hit || empty);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = probe_end ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      mem_rd      = (state_ff == ST_READ);
      do_write    = (state_ff == ST_CHECK) && (hit || empty) && (mode_ff == MODE_INCREMENT);
      mem_wr      = (state_ff == ST_CLEAR) || do_write;
      mem_wr_addr = (state_ff == ST_CLEAR) ? clr_idx_ff : addr_ff;
      if (state_ff == ST_CLEAR) begin
         mem_wr_data = '0;
      end else begin
         mem_wr_data = '{valid: 1'b1, key: key_ff, count: new_count};
      end
      rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_idx_ff     <= '0;
         best_count_ff  <= '0;
         best_key_ff    <= '0;
         least_count_ff <= BOTTOM_START;
         least_key_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         if (do_write) begin
            if (new_count > best_count_ff) begin
               best_count_ff <= new_count;
               best_key_ff   <= key_ff;
            end
            if (new_count < {15'd0, least_count_ff}) begin
               least_count_ff <= new_count[16:0];
               least_key_ff   <= key_ff;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff <= req_data.mode;
         key_ff  <= req_data.key;
      end
      if (state_ff == ST_HASH) begin
         addr_ff      <= hash_home;
         probe_cnt_ff <= '0;
      end else if ((state_ff == ST_CHECK) && !probe_end) begin
         addr_ff      <= next_addr;
         probe_cnt_ff <= probe_cnt_ff + 1'b1;
      end
      if (state_ff == ST_CHECK) begin
         count_ff <= res_count;
         full_ff  <= res_full;
      end
      if (rsp_load) begin
         rsp_ff.key_count    <= count_ff;
         rsp_ff.top_count    <= best_count_ff;
         rsp_ff.top_key      <= best_key_ff;
         rsp_ff.bottom_count <= least_count_ff;
         rsp_ff.bottom_key   <= least_key_ff;
         rsp_ff.table_full   <= full_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_accept_starts_hash: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_HASH))
      else $error("accepted item did not enter hashing");

   a_hash_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == ST_HASH))
      else $error("hash result arrived outside hashing");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised without a finished item");

   a_full_has_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.table_full) |-> (rsp_ff.key_count == 32'd0))
      else $error("table full result carries a count");

   a_bottom_bound: assert property (@(posedge clock) disable iff (reset)
      least_count_ff <= BOTTOM_START)
      else $error("bottom count above its start value");
`endif

endmodule

`default_nettype wire
